@@ rtl/core/saa_pkg.sv @@
// shared widths and constants for the sensor activity argmax unit
package saa_pkg;

	localparam int SENSORS_DEF  = 24;
	localparam int FRAME_W      = 24;
	localparam int CNT_W        = 10;
	localparam int SENSOR_ID_W  = 5;
	localparam logic [CNT_W-1:0] WINDOW_RESET = 10'd350;

endpackage

@@ rtl/core/sensor_activity_argmax_unit.sv @@
// sensor activity argmax unit: per-sensor activity counters and serial best-sensor scan
//
// Input channel: a frame beat is taken at a rising edge where start is high and
// busy is low. Every clear bit in sensor_frame adds one to that sensor's counter.
// A frame that does not close the window leaves the block idle, so frames may follow
// back to back.
// The frame that closes the window (frames seen reaches or passes window_frames,
// a setting of zero counting as one) starts the scan: the counter row is shifted
// past a single comparator, one sensor per cycle, while zeros shift in behind so
// the row is cleared by the time the scan ends.
// Result channel: done pulses for exactly one cycle with best_sensor and
// best_count, in the cycle after the last scan step. The receiver cannot
// stall; a result is presented once and never held. A new frame may be taken
// in the done cycle. The scan of a closed window runs the length of the
// counter shift line.
// Configuration: wr_en/wr_data write window_frames without clearing the counters;
// the user must write it only while the block is idle; the block does not enforce it.
// Reset (arst_n low): counters and frame count cleared, window_frames to 350,
// no scan running.
module sensor_activity_argmax_unit
	import saa_pkg::*;
#(
	parameter int SENSORS = SENSORS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CNT_W-1:0]       wr_data,
	input  logic                   start,
	input  logic [FRAME_W-1:0]     sensor_frame,
	output logic                   busy,
	output logic                   done,
	output logic [SENSOR_ID_W-1:0] best_sensor,
	output logic [CNT_W-1:0]       best_count
);

	localparam int IDX_W = (SENSORS > 1) ? $clog2(SENSORS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SENSORS - 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   window_q;
	logic [CNT_W-1:0]   frames_q;
	logic [CNT_W-1:0]   cnt_q [SENSORS];
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [CNT_W-1:0]   best_cnt_q;

	logic [SENSORS-1:0] hit;
	logic [CNT_W-1:0]   win_eff;
	logic [CNT_W-1:0]   frames_nxt;
	logic               close_win;
	logic               accept;
	logic               take;

	// active-low sensor bits; sensors beyond the frame read as detected
	always_comb begin
		for (int i = 0; i < SENSORS; i++) begin
			if (i < FRAME_W) begin
				hit[i] = ~sensor_frame[i];
			end else begin
				hit[i] = 1'b1;
			end
		end
	end

	// window bookkeeping
	assign win_eff    = (window_q == '0) ? CNT_W'(1) : window_q;
	assign frames_nxt = frames_q + CNT_W'(1);
	assign close_win  = (frames_nxt >= win_eff) || (frames_nxt == '0);
	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q == ST_SCAN);

	// head of the shift line against the running best; saturated sensors skipped
	assign take = (cnt_q[0] > best_cnt_q) && (cnt_q[0] != win_eff);

	// control, counters, shift line and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= WINDOW_RESET;
			frames_q   <= '0;
			idx_q      <= '0;
			best_idx_q <= '0;
			best_cnt_q <= '0;
			done       <= 1'b0;
			best_sensor <= '0;
			best_count <= '0;
			for (int i = 0; i < SENSORS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			done <= 1'b0;
			if (wr_en) begin
				window_q <= wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						for (int i = 0; i < SENSORS; i++) begin
							cnt_q[i] <= cnt_q[i] + CNT_W'(hit[i]);
						end
						if (close_win) begin
							frames_q <= '0;
							idx_q    <= '0;
							state_q  <= ST_SCAN;
						end else begin
							frames_q <= frames_nxt;
						end
					end
				end
				ST_SCAN: begin
					// shift one sensor count per cycle, zeros fill from the top
					for (int i = 0; i < SENSORS - 1; i++) begin
						cnt_q[i] <= cnt_q[i+1];
					end
					cnt_q[SENSORS-1] <= '0;
					if (idx_q == '0) begin
						best_idx_q <= '0;
						best_cnt_q <= cnt_q[0];
					end else if (take) begin
						best_idx_q <= idx_q;
						best_cnt_q <= cnt_q[0];
					end
					if (idx_q == LAST_IDX) begin
						done    <= 1'b1;
						state_q <= ST_IDLE;
						if ((idx_q != '0) && take) begin
							best_sensor <= SENSOR_ID_W'(idx_q);
							best_count  <= cnt_q[0];
						end else if (idx_q == '0) begin
							best_sensor <= '0;
							best_count  <= cnt_q[0];
						end else begin
							best_sensor <= SENSOR_ID_W'(best_idx_q);
							best_count  <= best_cnt_q;
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result only appears once the scan has ended
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while scan still running");

	// a scan only starts from an accepted frame
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("scan started without a frame beat");

	// chosen index lies within the sensor row
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ({1'b0, best_sensor} < (SENSOR_ID_W+1)'(SENSORS)))
		else $error("best sensor index out of range");

	// one result beat per window
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beat repeated");

endmodule

@@ bench/tb.sv @@
// testbench for the sensor activity argmax unit: frame windows, best-sensor votes, window register
`timescale 1ns / 100ps

module tb
	import saa_pkg::*;
();

	localparam int SENSORS    = SENSORS_DEF;
	localparam int STALL_CAP  = 1000;

	typedef struct packed {
		logic [SENSOR_ID_W-1:0] sensor;
		logic [CNT_W-1:0]       count;
	} vote_t;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [CNT_W-1:0]       wr_data;
	logic                   start;
	logic [FRAME_W-1:0]     sensor_frame;
	logic                   busy;
	logic                   done;
	logic [SENSOR_ID_W-1:0] best_sensor;
	logic [CNT_W-1:0]       best_count;

	// own copy of the block state
	logic [CNT_W-1:0] window_len;
	logic [CNT_W-1:0] activity[SENSORS];
	logic [CNT_W-1:0] frames_in_window;

	vote_t pending_votes[$];
	vote_t oldest_vote;
	int    failures;
	int    votes_seen;
	int    frames_sent;
	int    quiet_cycles;
	bit    gaps_on;

	sensor_activity_argmax_unit #(.SENSORS(SENSORS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_data      (wr_data),
		.start        (start),
		.sensor_frame (sensor_frame),
		.busy         (busy),
		.done         (done),
		.best_sensor  (best_sensor),
		.best_count   (best_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// count one frame into the window and close it when full
	function automatic void tally_frame(logic [FRAME_W-1:0] frame);
		logic [CNT_W-1:0] span;
		int               top;
		vote_t            vote;
		span = (window_len == '0) ? CNT_W'(1) : window_len;
		for (int i = 0; i < SENSORS; i++) begin
			if (!frame[i])
				activity[i] = activity[i] + CNT_W'(1);
		end
		frames_in_window = frames_in_window + CNT_W'(1);
		if (frames_in_window < span && frames_in_window != '0)
			return;
		// scan from sensor 0, skipping saturated sensors
		top = 0;
		for (int i = 1; i < SENSORS; i++) begin
			if (activity[i] > activity[top] && activity[i] != span)
				top = i;
		end
		vote.sensor = top[SENSOR_ID_W-1:0];
		vote.count  = activity[top];
		pending_votes.push_back(vote);
		for (int i = 0; i < SENSORS; i++)
			activity[i] = '0;
		frames_in_window = '0;
	endfunction

	// random frame: hot sensors always detected, cold never, the rest at pct percent
	function automatic logic [FRAME_W-1:0] make_frame(int pct, logic [FRAME_W-1:0] hot,
			logic [FRAME_W-1:0] cold);
		logic [FRAME_W-1:0] frame;
		for (int i = 0; i < FRAME_W; i++)
			frame[i] = !(hot[i] || (!cold[i] && $urandom_range(0, 99) < pct));
		return frame;
	endfunction

	function automatic logic [FRAME_W-1:0] sparse_mask(int pct);
		logic [FRAME_W-1:0] mask;
		for (int i = 0; i < FRAME_W; i++)
			mask[i] = ($urandom_range(0, 99) < pct);
		return mask;
	endfunction

	// send one frame beat, with an occasional gap before it
	task automatic send_frame(input logic [FRAME_W-1:0] frame);
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start        <= 1'b1;
		sensor_frame <= frame;
		@(posedge clk);
		while (busy) @(posedge clk);
		tally_frame(frame);
		frames_sent++;
	endtask

	// stop sending and let every expected vote come out
	task automatic settle();
		start <= 1'b0;
		while (pending_votes.size() != 0) @(posedge clk);
		repeat (SENSORS + 2) @(posedge clk);
	endtask

	task automatic set_window(input logic [CNT_W-1:0] frames);
		settle();
		wr_en   <= 1'b1;
		wr_data <= frames;
		@(posedge clk);
		wr_en   <= 1'b0;
		window_len = frames;
	endtask

	// reset window still in force: mixed frames, no vote expected yet
	task automatic test_reset_window();
		send_frame(24'h000000);
		send_frame(24'hFFFFFF);
		send_frame(24'hAAAAAA);
		send_frame(24'h555555);
	endtask

	// window written below the frames already seen closes on the next frame
	task automatic test_short_window();
		set_window(CNT_W'(2));
		send_frame(24'h0F0F0F);
	endtask

	// a zero window acts as one: a vote every frame, a count of one saturates
	task automatic test_zero_window();
		set_window('0);
		send_frame(24'hFFFFFF);
		send_frame(24'h000000);
		send_frame(24'hFFFFFE);
		send_frame(24'h7FFFFF);
	endtask

	// sensor 0 kept while saturated, saturated later sensors skipped, lowest index on ties
	task automatic test_saturation();
		set_window(CNT_W'(3));
		send_frame(~24'h0000A1);
		send_frame(~24'h0000A1);
		send_frame(~24'h000081);
		send_frame(~24'h801211);
		send_frame(~24'h801210);
		send_frame(~24'h001000);
	endtask

	// largest window written, counters kept over writes, then shortened
	task automatic test_max_window();
		set_window(CNT_W'(1023));
		send_frame(24'h123456);
		send_frame(24'hEDCBA9);
		set_window(CNT_W'(1));
		send_frame(24'hF0F0F0);
	endtask

	task automatic test_random();
		int                 span;
		int                 pick;
		int                 pct;
		logic [FRAME_W-1:0] hot;
		logic [FRAME_W-1:0] cold;
		// one full long window, back to back
		gaps_on = 1'b0;
		set_window(CNT_W'(200));
		hot  = sparse_mask(10);
		cold = sparse_mask(10) & ~hot;
		pct  = $urandom_range(0, 100);
		repeat (200) send_frame(make_frame(pct, hot, cold));
		gaps_on = 1'b1;
		// mostly short windows so votes come often
		while (frames_sent < 900) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				span = 0;
			else if (pick < 3)
				span = $urandom_range(1, 4);
			else if (pick < 9)
				span = $urandom_range(5, 16);
			else
				span = $urandom_range(17, 64);
			set_window(span[CNT_W-1:0]);
			hot  = sparse_mask($urandom_range(0, 25));
			cold = sparse_mask($urandom_range(0, 25)) & ~hot;
			pct  = $urandom_range(0, 100);
			repeat ($urandom_range(1, 3 * (span == 0 ? 1 : span) + 1))
				send_frame(make_frame(pct, hot, cold));
		end
	endtask

	// compare each result beat with the oldest expected vote
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_votes.size() == 0) begin
				$error("unexpected result: best_sensor %0d best_count %0d",
					best_sensor, best_count);
				failures++;
			end else begin
				oldest_vote = pending_votes.pop_front();
				votes_seen++;
				if (best_sensor !== oldest_vote.sensor) begin
					$error("best_sensor: expected %0d, got %0d", oldest_vote.sensor, best_sensor);
					failures++;
				end
				if (best_count !== oldest_vote.count) begin
					$error("best_count: expected %0d, got %0d", oldest_vote.count, best_count);
					failures++;
				end
			end
		end
	end

	// watchdog on cycles with no beat in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_CAP) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		wr_en        = 1'b0;
		wr_data      = '0;
		start        = 1'b0;
		sensor_frame = '0;
		failures     = 0;
		votes_seen   = 0;
		frames_sent  = 0;
		quiet_cycles = 0;
		gaps_on      = 1'b1;
		window_len       = WINDOW_RESET;
		frames_in_window = '0;
		for (int i = 0; i < SENSORS; i++)
			activity[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_short_window();
		test_zero_window();
		test_saturation();
		test_max_window();
		test_random();

		settle();
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/saa_pkg.sv
rtl/core/sensor_activity_argmax_unit.sv
bench/tb.sv
